>>> hw/rtl/bde_pkg.sv
// Package of the bitmap drawing engine: command codes, pen codes,
// register indexes, default sizes and the pen function. No dependencies.
package bde_pkg;

  localparam int MAX_ROW_BYTES_DEF = 64;
  localparam int MAX_ROWS_DEF      = 256;

  localparam logic [3:0] OP_PLOT    = 4'd0;
  localparam logic [3:0] OP_LINE    = 4'd1;
  localparam logic [3:0] OP_FILL    = 4'd2;
  localparam logic [3:0] OP_ROT_R   = 4'd3;
  localparam logic [3:0] OP_ROT_L   = 4'd4;
  localparam logic [3:0] OP_PEEK    = 4'd5;
  localparam logic [3:0] OP_CLEAR   = 4'd6;
  localparam logic [3:0] OP_LOAD_B  = 4'd7;
  localparam logic [3:0] OP_READ_B  = 4'd8;

  localparam logic [1:0] PEN_CLR = 2'd0;
  localparam logic [1:0] PEN_SET = 2'd1;
  localparam logic [1:0] PEN_INV = 2'd2;

  localparam logic [1:0] REG_PEN    = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] LEFT_BIT  = 8'h80;

  function automatic logic [7:0] apply_pen(input logic [7:0] b, input logic [7:0] m,
                                           input logic [1:0] mode);
    logic [7:0] r;
    case (mode)
      PEN_CLR: r = b & ~m;
      PEN_SET: r = b | m;
      PEN_INV: r = b ^ m;
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/bde_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module bde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> hw/rtl/bitmap_draw_engine.sv
// Top level of the bitmap drawing engine: command sequencer around one
// byte-wide bitmap RAM. Depends on bde_pkg and bde_ram.
//
// After reset the block zeroes the whole bitmap RAM and takes no item
// meanwhile; configuration writes are taken at any time. Every pixel plot is
// a read-modify-write of one RAM byte over the single RAM port: a plot or read
// pixel touches one byte, a line plots each pixel along its path, a rectangle
// visits every pixel of its whole unclipped area, a rotate works row by row
// through each row's bytes, a clear writes every byte of the image, and load
// or read byte touches one byte. One item is worked at a time; a finished
// result waits in the output register, and the next item is accepted only
// once that result leaves, at the earliest in the same cycle.
module bitmap_draw_engine
  import bde_pkg::*;
#(
  parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF,
  parameter int MAX_ROWS      = MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // operation, x_a, y_a, x_b, y_b, byte_index, byte_value (lowest bit up)
  input  logic [63:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pixel_value, byte_out, outside (lowest bit up)
  output logic [15:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int DEPTH = MAX_ROW_BYTES * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int WBW   = $clog2(MAX_ROW_BYTES + 1);
  localparam int HW    = $clog2(MAX_ROWS + 1);
  localparam int PW    = HW + WBW + 1;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PRD   = 4'd2;
  localparam logic [3:0] S_PWR   = 4'd3;
  localparam logic [3:0] S_RPRE  = 4'd4;
  localparam logic [3:0] S_RPREW = 4'd5;
  localparam logic [3:0] S_RRD   = 4'd6;
  localparam logic [3:0] S_RWR   = 4'd7;
  localparam logic [3:0] S_CLR   = 4'd8;
  localparam logic [3:0] S_BRD   = 4'd9;

  logic [1:0] pen_r;
  logic [6:0] wbcfg_r;
  logic [8:0] hcfg_r;

  logic [3:0]  state_r, state_nxt;
  logic [3:0]  op_r, op_nxt;
  logic [8:0]  cx_r, cx_nxt, xe_r, xe_nxt, lx_r, lx_nxt;
  logic [7:0]  cy_r, cy_nxt, ye_r, ye_nxt;
  logic        sx_r, sx_nxt, sy_r, sy_nxt;
  logic [9:0]  dx_r, dx_nxt, dy_r, dy_nxt, steps_r, steps_nxt;
  logic signed [11:0] acc_r, acc_nxt;
  logic [HW-1:0]  row_r, row_nxt;
  logic [WBW-1:0] col_r, col_nxt;
  logic        carry_r, carry_nxt;
  logic [AW-1:0] ic_r, ic_nxt;
  logic        ov_r, ov_nxt;
  logic        pix_r, pix_nxt, outs_r, outs_nxt;
  logic [7:0]  bout_r, bout_nxt;

  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [7:0]    ram_wd, ram_rd;

  logic [WBW-1:0] wb_eff;
  logic [HW-1:0]  h_eff;
  logic [11:0]    xlim;
  logic [3:0]     i_op;
  logic [8:0]     i_xa, i_xb;
  logic [7:0]     i_ya, i_yb;
  logic [13:0]    i_idx;
  logic [7:0]     i_val;
  logic           acc_in, i_inimg, c_inimg, idx_ok, rot_right;
  logic [PW-1:0]  pa_full, ra_full;
  logic [7:0]     mask;
  logic [8:0]     nx;
  logic [7:0]     ny;
  logic signed [11:0] nacc;
  logic [9:0]     nsteps;

  bde_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .addr(ram_addr), .we(ram_we), .wdata(ram_wd), .rdata(ram_rd)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE) && (!ov_r || out_tready);
  assign acc_in     = in_tvalid && in_tready;
  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, outs_r, bout_r, pix_r};

  assign i_op  = in_tdata[3:0];
  assign i_xa  = in_tdata[12:4];
  assign i_ya  = in_tdata[20:13];
  assign i_xb  = in_tdata[29:21];
  assign i_yb  = in_tdata[37:30];
  assign i_idx = in_tdata[51:38];
  assign i_val = in_tdata[59:52];

  always_comb begin
    if (wbcfg_r == 7'd0) wb_eff = WBW'(1);
    else if (10'(wbcfg_r) > 10'(MAX_ROW_BYTES)) wb_eff = WBW'(MAX_ROW_BYTES);
    else wb_eff = WBW'(wbcfg_r);
    if (hcfg_r == 9'd0) h_eff = HW'(1);
    else if (11'(hcfg_r) > 11'(MAX_ROWS)) h_eff = HW'(MAX_ROWS);
    else h_eff = HW'(hcfg_r);
  end

  assign xlim    = 12'({wb_eff, 3'b000});
  assign i_inimg = (12'(i_xa) < xlim) && (12'(i_ya) < 12'(h_eff));
  assign c_inimg = (12'(cx_r) < xlim) && (12'(cy_r) < 12'(h_eff));
  assign idx_ok  = 32'(i_idx) < 32'(DEPTH);
  assign pa_full = PW'(cy_r) * PW'(wb_eff) + PW'(cx_r[8:3]);
  assign ra_full = PW'(row_r) * PW'(wb_eff) + PW'(col_r);
  assign mask    = LEFT_BIT >> cx_r[2:0];
  assign rot_right = (op_r == OP_ROT_R);

  always_comb begin
    nx = cx_r;
    ny = cy_r;
    nacc = acc_r;
    if (acc_r < 0) begin
      ny = sy_r ? cy_r - 8'd1 : cy_r + 8'd1;
      nacc = acc_r + 12'(dx_r);
    end else begin
      nx = sx_r ? cx_r - 9'd1 : cx_r + 9'd1;
      nacc = acc_r - 12'(dy_r);
    end
    nsteps = steps_r - 10'd1;
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    cx_nxt = cx_r; cy_nxt = cy_r; xe_nxt = xe_r; ye_nxt = ye_r; lx_nxt = lx_r;
    sx_nxt = sx_r; sy_nxt = sy_r; dx_nxt = dx_r; dy_nxt = dy_r;
    steps_nxt = steps_r; acc_nxt = acc_r;
    row_nxt = row_r; col_nxt = col_r; carry_nxt = carry_r;
    ic_nxt = ic_r;
    ov_nxt = ov_r && !out_tready;
    pix_nxt = pix_r; outs_nxt = outs_r; bout_nxt = bout_r;
    ram_addr = AW'(pa_full);
    ram_we = 1'b0;
    ram_wd = BYTE_ZERO;
    case (state_r)
      S_INIT: begin
        ram_addr = ic_r;
        ram_we = 1'b1;
        ic_nxt = ic_r + AW'(1);
        if (32'(ic_r) == DEPTH - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc_in) begin
          op_nxt = i_op;
          pix_nxt = 1'b0;
          bout_nxt = BYTE_ZERO;
          outs_nxt = (i_op <= OP_FILL || i_op == OP_PEEK) ? !i_inimg : 1'b0;
          cx_nxt = i_xa; cy_nxt = i_ya; xe_nxt = i_xb; ye_nxt = i_yb;
          sx_nxt = i_xa > i_xb;
          sy_nxt = i_ya > i_yb;
          dx_nxt = (i_xb > i_xa) ? 10'(i_xb) - 10'(i_xa) : 10'(i_xa) - 10'(i_xb);
          dy_nxt = (i_yb > i_ya) ? 10'(i_yb) - 10'(i_ya) : 10'(i_ya) - 10'(i_yb);
          acc_nxt = (i_xa == i_xb) ? -12'sd1 : 12'sd0;
          steps_nxt = dx_nxt + dy_nxt;
          row_nxt = '0;
          col_nxt = '0;
          ram_addr = AW'(i_idx);
          case (i_op)
            OP_PLOT, OP_LINE, OP_PEEK: state_nxt = S_PRD;
            OP_FILL: begin
              cx_nxt = (i_xa < i_xb) ? i_xa : i_xb;
              lx_nxt = cx_nxt;
              xe_nxt = (i_xa < i_xb) ? i_xb : i_xa;
              cy_nxt = (i_ya < i_yb) ? i_ya : i_yb;
              ye_nxt = (i_ya < i_yb) ? i_yb : i_ya;
              state_nxt = S_PRD;
            end
            OP_ROT_R: begin
              col_nxt = wb_eff - WBW'(1);
              state_nxt = S_RPRE;
            end
            OP_ROT_L: state_nxt = S_RPRE;
            OP_CLEAR: state_nxt = S_CLR;
            OP_LOAD_B: begin
              ram_we = idx_ok;
              ram_wd = i_val;
              ov_nxt = 1'b1;
            end
            OP_READ_B: begin
              if (idx_ok) state_nxt = S_BRD;
              else ov_nxt = 1'b1;
            end
            default: ov_nxt = 1'b1;
          endcase
        end
      end
      S_PRD: state_nxt = S_PWR;
      S_PWR: begin
        state_nxt = S_IDLE;
        if (op_r == OP_PEEK) begin
          pix_nxt = c_inimg && ((ram_rd & mask) != BYTE_ZERO);
          ov_nxt = 1'b1;
        end else begin
          ram_we = c_inimg;
          ram_wd = apply_pen(ram_rd, mask, pen_r);
          if (op_r == OP_LINE) begin
            if (steps_r != 10'd0) begin
              cx_nxt = nx; cy_nxt = ny; acc_nxt = nacc; steps_nxt = nsteps;
              if (nsteps != 10'd0 && !(nx == xe_r && ny == ye_r)) state_nxt = S_PRD;
              else ov_nxt = 1'b1;
            end else begin
              ov_nxt = 1'b1;
            end
          end else if (op_r == OP_FILL) begin
            if (cx_r == xe_r) begin
              cx_nxt = lx_r;
              if (cy_r == ye_r) ov_nxt = 1'b1;
              else begin
                cy_nxt = cy_r + 8'd1;
                state_nxt = S_PRD;
              end
            end else begin
              cx_nxt = cx_r + 9'd1;
              state_nxt = S_PRD;
            end
          end else begin
            ov_nxt = 1'b1;
          end
        end
      end
      S_RPRE: begin
        ram_addr = AW'(ra_full);
        state_nxt = S_RPREW;
      end
      S_RPREW: begin
        carry_nxt = rot_right ? ram_rd[0] : ram_rd[7];
        col_nxt = rot_right ? '0 : wb_eff - WBW'(1);
        state_nxt = S_RRD;
      end
      S_RRD: begin
        ram_addr = AW'(ra_full);
        state_nxt = S_RWR;
      end
      S_RWR: begin
        ram_addr = AW'(ra_full);
        ram_we = 1'b1;
        ram_wd = rot_right ? {carry_r, ram_rd[7:1]} : {ram_rd[6:0], carry_r};
        carry_nxt = rot_right ? ram_rd[0] : ram_rd[7];
        state_nxt = S_RRD;
        if (rot_right ? (col_r == wb_eff - WBW'(1)) : (col_r == '0)) begin
          col_nxt = rot_right ? wb_eff - WBW'(1) : '0;
          if (row_r == h_eff - HW'(1)) begin
            state_nxt = S_IDLE;
            ov_nxt = 1'b1;
          end else begin
            row_nxt = row_r + HW'(1);
            state_nxt = S_RPRE;
          end
        end else begin
          col_nxt = rot_right ? col_r + WBW'(1) : col_r - WBW'(1);
        end
      end
      S_CLR: begin
        ram_addr = AW'(ra_full);
        ram_we = 1'b1;
        if (col_r == wb_eff - WBW'(1)) begin
          col_nxt = '0;
          if (row_r == h_eff - HW'(1)) begin
            state_nxt = S_IDLE;
            ov_nxt = 1'b1;
          end else begin
            row_nxt = row_r + HW'(1);
          end
        end else begin
          col_nxt = col_r + WBW'(1);
        end
      end
      S_BRD: begin
        bout_nxt = ram_rd;
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ic_r    <= '0;
      ov_r    <= 1'b0;
      pen_r   <= PEN_INV;
      wbcfg_r <= 7'd4;
      hcfg_r  <= 9'd28;
    end else begin
      state_r <= state_nxt;
      ic_r    <= ic_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_PEN:    pen_r   <= cfg_data[1:0];
          REG_WIDTH:  wbcfg_r <= cfg_data[6:0];
          REG_HEIGHT: hcfg_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; xe_r <= xe_nxt; ye_r <= ye_nxt; lx_r <= lx_nxt;
    sx_r <= sx_nxt; sy_r <= sy_nxt; dx_r <= dx_nxt; dy_r <= dy_nxt;
    steps_r <= steps_nxt; acc_r <= acc_nxt;
    row_r <= row_nxt; col_r <= col_nxt; carry_r <= carry_nxt;
    pix_r <= pix_nxt; outs_r <= outs_nxt; bout_r <= bout_nxt;
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_rmw_pair: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PRD |=> state_r == S_PWR) else $error("read not followed by write");
  a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r == S_IDLE) |-> (acc_in && i_op == OP_LOAD_B))
    else $error("stray write in idle");
  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INIT |-> !ov_r) else $error("result during clearing pass");
`endif

endmodule
